FILE: hdl/mid4_pkg.sv
// Shared constants and types for the 4x4 matrix inverse and determinant unit.
`default_nettype none
package mid4_pkg;
	localparam int DIM       = 4;
	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int ACC_W     = 64;
	localparam int IDX_W     = $clog2(DIM);
	localparam int ADDR_W    = $clog2(DIM * DIM);
	localparam int NUM_W     = ACC_W + FRAC_BITS;
	localparam int DCNT_W    = $clog2(NUM_W + 1);

	// Operands of one multiply-accumulate pass.
	typedef struct packed {
		logic signed [ELEM_W-1:0] e;
		logic signed [ACC_W-1:0]  v;
		logic                     flip;
		logic signed [ACC_W-1:0]  acc;
	} mac_op_t;
endpackage
`default_nettype wire

FILE: hdl/mid4_mac.sv
// Shared multiply-accumulate unit: acc + (e * v) >> FRAC_BITS, with saturation.
`default_nettype none
module mid4_mac import mid4_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire mac_op_t                 op,
	output logic                         done,
	output logic signed [ACC_W-1:0]      res
);
	typedef enum logic [4:0] {
		M_IDLE  = 5'b00001,
		M_LO    = 5'b00010,
		M_HI    = 5'b00100,
		M_SHIFT = 5'b01000,
		M_ADD   = 5'b10000
	} mstate_t;

	mstate_t                  state_q;
	logic [ELEM_W-1:0]        ae_q;
	logic [ACC_W-1:0]         av_q;
	logic                     neg_q;
	logic signed [ACC_W-1:0]  acc_q;
	logic [2*ELEM_W-1:0]      p0_q, p1_q;
	logic signed [ACC_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]  res_q;
	logic                     done_q;

	logic [ELEM_W-1:0]        mul_b;
	logic [2*ELEM_W-1:0]      mul_p;
	logic [ACC_W+ELEM_W-1:0]  sum96;
	logic [ACC_W-1:0]         mlo;
	logic                     mhi_nz;
	logic signed [ACC_W-1:0]  prod_d;
	logic [ACC_W:0]           ssum;

	// One 32x32 multiplier serves both halves of the wide operand.
	assign mul_b = (state_q == M_LO) ? av_q[ELEM_W-1:0] : av_q[ACC_W-1:ELEM_W];
	assign mul_p = (2*ELEM_W)'(ae_q) * (2*ELEM_W)'(mul_b);

	assign sum96  = {{ELEM_W{1'b0}}, p0_q} + {p1_q, {ELEM_W{1'b0}}};
	assign mlo    = sum96[FRAC_BITS +: ACC_W];
	assign mhi_nz = |sum96[ACC_W+ELEM_W-1:ACC_W+FRAC_BITS];

	always_comb begin
		if (neg_q) begin
			if (mhi_nz || (mlo > {1'b1, {(ACC_W-1){1'b0}}}))
				prod_d = {1'b1, {(ACC_W-1){1'b0}}};
			else
				prod_d = ACC_W'(-mlo);
		end else begin
			if (mhi_nz || mlo[ACC_W-1])
				prod_d = {1'b0, {(ACC_W-1){1'b1}}};
			else
				prod_d = mlo;
		end
	end

	assign ssum = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE:  if (start) state_q <= M_LO;
				M_LO:    state_q <= M_HI;
				M_HI:    state_q <= M_SHIFT;
				M_SHIFT: state_q <= M_ADD;
				M_ADD: begin
					state_q <= M_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_IDLE && start) begin
			ae_q  <= op.e[ELEM_W-1] ? ELEM_W'(-op.e) : op.e;
			av_q  <= op.v[ACC_W-1] ? ACC_W'(-op.v) : op.v;
			neg_q <= op.e[ELEM_W-1] ^ op.v[ACC_W-1] ^ op.flip;
			acc_q <= op.acc;
		end
		if (state_q == M_LO)
			p0_q <= mul_p;
		if (state_q == M_HI)
			p1_q <= mul_p;
		if (state_q == M_SHIFT)
			prod_q <= prod_d;
		if (state_q == M_ADD) begin
			if (ssum[ACC_W] != ssum[ACC_W-1])
				res_q <= ssum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
			else
				res_q <= ssum[ACC_W-1:0];
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

FILE: hdl/mid4_div.sv
// Restoring divider, one quotient bit per cycle: (num << FRAC_BITS) / den, saturated.
`default_nettype none
module mid4_div import mid4_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [ACC_W-1:0]  num,
	input  wire logic signed [ACC_W-1:0]  den,
	input  wire logic                     negate,
	output logic                          done,
	output logic signed [ELEM_W-1:0]      quo
);
	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_FIN  = 3'b100
	} dstate_t;

	dstate_t              state_q;
	logic [NUM_W-1:0]     n_q;
	logic [ACC_W-1:0]     d_q;
	logic [ACC_W-1:0]     r_q;
	logic [ELEM_W-1:0]    q_q;
	logic                 ovf_q;
	logic                 neg_q;
	logic [DCNT_W-1:0]    cnt_q;
	logic                 done_q;
	logic [ELEM_W-1:0]    quo_q;

	logic [ACC_W:0]       rr;
	logic                 ge;
	logic [ACC_W:0]       rdiff;
	logic [ACC_W-1:0]     num_mag;

	assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : num;
	assign rr      = {r_q, n_q[NUM_W-1]};
	assign ge      = rr >= {1'b0, d_q};
	assign rdiff   = rr - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: if (start) state_q <= D_RUN;
				D_RUN:  if (cnt_q == DCNT_W'(1)) state_q <= D_FIN;
				D_FIN: begin
					state_q <= D_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			n_q   <= {num_mag, {FRAC_BITS{1'b0}}};
			d_q   <= den[ACC_W-1] ? ACC_W'(-den) : den;
			neg_q <= num[ACC_W-1] ^ den[ACC_W-1] ^ negate;
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
			cnt_q <= DCNT_W'(NUM_W);
		end
		if (state_q == D_RUN) begin
			r_q   <= ge ? rdiff[ACC_W-1:0] : rr[ACC_W-1:0];
			q_q   <= {q_q[ELEM_W-2:0], ge};
			ovf_q <= ovf_q | q_q[ELEM_W-1];
			n_q   <= {n_q[NUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - DCNT_W'(1);
		end
		if (state_q == D_FIN) begin
			if (ovf_q || q_q[ELEM_W-1])
				quo_q <= neg_q ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
			else
				quo_q <= neg_q ? ELEM_W'(-q_q) : q_q;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

FILE: hdl/matrix4_inverse_determinant_unit.sv
// Top level: 4x4 matrix inverse and determinant by cofactor expansion.
`default_nettype none
// Usage:
// An item is one matrix element, signed Q15.16, taken on a rising edge where
// start is high and busy is low. Elements arrive in row-major order; the first
// fifteen are only stored, one per cycle, and busy stays low.
// The sixteenth item starts a run. busy then stays high while one shared
// multiply-accumulate unit (one 32x32 multiplier, used twice per product)
// forms the determinant from 40 products and then, if it is non-zero, for
// each of the 16 inverse elements in row-major order, a 3x3 cofactor from 9
// products and one quotient from the bit-serial divider. Each result is
// shown for exactly one cycle with result_valid high, carrying row, column,
// the determinant, the singular flag and last_of_run. The receiver cannot
// stall the block; it must take every result as it appears.
// busy drops in the cycle after the result marked last_of_run.
// Reset clears the load count and the sequencer; the element store is not
// cleared, because every entry is written before a run begins.
module matrix4_inverse_determinant_unit import mid4_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic signed [ELEM_W-1:0] element,
	output logic                          result_valid,
	output logic signed [ELEM_W-1:0]      inverse_element,
	output logic [IDX_W-1:0]              row,
	output logic [IDX_W-1:0]              column,
	output logic signed [ACC_W-1:0]       determinant,
	output logic                          singular,
	output logic                          last_of_run
);
	typedef enum logic [6:0] {
		S_LOAD     = 7'b0000001,
		S_FETCH    = 7'b0000010,
		S_MAC_GO   = 7'b0000100,
		S_MAC_WAIT = 7'b0001000,
		S_DIV_GO   = 7'b0010000,
		S_DIV_WAIT = 7'b0100000,
		S_EMIT     = 7'b1000000
	} state_t;

	// Micro-operations of one cofactor: the two products of a 2x2 minor, the
	// expansion term of the 3x3 cofactor, and the expansion term of the
	// determinant itself.
	typedef enum logic [1:0] {
		OP_PA_QB = 2'd0,
		OP_PB_QA = 2'd1,
		OP_COF   = 2'd2,
		OP_DET   = 2'd3
	} op_t;

	state_t                   state_q;
	op_t                      op_q;
	logic                     out_phase_q;
	logic [IDX_W-1:0]         i_q, j_q, r_q, c_q;
	logic [ADDR_W-1:0]        load_count_q;
	logic signed [ACC_W-1:0]  acc2_q, acc3_q, det_q;
	logic signed [ELEM_W-1:0] ie_q;

	// Element store, two registered read ports.
	logic signed [ELEM_W-1:0] mem_q [DIM*DIM];
	logic signed [ELEM_W-1:0] rd_a_q, rd_b_q;
	logic [ADDR_W-1:0]        addr_a, addr_b;

	logic [IDX_W-1:0] xr, xc, sr0, sr1, sr2, sc0, sc1, sc2, srj, pr, qr;
	logic             accept;
	logic             last_rc;

	mac_op_t                  mac_op;
	logic                     mac_start, mac_done;
	logic signed [ACC_W-1:0]  mac_res;
	logic                     div_start, div_done;
	logic signed [ELEM_W-1:0] div_quo;

	// k-th index of 0..3 once index x is taken out.
	function automatic logic [IDX_W-1:0] skip(input logic [IDX_W-1:0] k,
						  input logic [IDX_W-1:0] x);
		return (k < x) ? k : k + IDX_W'(1);
	endfunction

	assign accept  = start && (state_q == S_LOAD);
	assign last_rc = (r_q == IDX_W'(DIM-1)) && (c_q == IDX_W'(DIM-1));

	// In the determinant pass, row i and column 0 are removed; for inverse
	// element (r,c), row c and column r are removed.
	assign xr  = out_phase_q ? c_q : i_q;
	assign xc  = out_phase_q ? r_q : '0;
	assign sr0 = skip(IDX_W'(0), xr);
	assign sr1 = skip(IDX_W'(1), xr);
	assign sr2 = skip(IDX_W'(2), xr);
	assign sc0 = skip(IDX_W'(0), xc);
	assign sc1 = skip(IDX_W'(1), xc);
	assign sc2 = skip(IDX_W'(2), xc);

	// Row j of the 3x3 expansion and the two rows left for its 2x2 minor.
	assign srj = (j_q == IDX_W'(0)) ? sr0 : (j_q == IDX_W'(1)) ? sr1 : sr2;
	assign pr  = (j_q == IDX_W'(0)) ? sr1 : sr0;
	assign qr  = (j_q == IDX_W'(2)) ? sr1 : sr2;

	always_comb begin
		unique case (op_q)
			OP_PA_QB: begin
				addr_a = {pr, sc1};
				addr_b = {qr, sc2};
			end
			OP_PB_QA: begin
				addr_a = {pr, sc2};
				addr_b = {qr, sc1};
			end
			OP_COF: begin
				addr_a = {srj, sc0};
				addr_b = {srj, sc0};
			end
			OP_DET: begin
				addr_a = {i_q, IDX_W'(0)};
				addr_b = {i_q, IDX_W'(0)};
			end
			default: begin
				addr_a = '0;
				addr_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept)
			mem_q[load_count_q] <= element;
		rd_a_q <= mem_q[addr_a];
		rd_b_q <= mem_q[addr_b];
	end

	// Operands of the shared unit; a zero accumulator opens each sum.
	always_comb begin
		mac_op.e = rd_a_q;
		unique case (op_q)
			OP_PA_QB: begin
				mac_op.v    = {{(ACC_W-ELEM_W){rd_b_q[ELEM_W-1]}}, rd_b_q};
				mac_op.flip = 1'b0;
				mac_op.acc  = '0;
			end
			OP_PB_QA: begin
				mac_op.v    = {{(ACC_W-ELEM_W){rd_b_q[ELEM_W-1]}}, rd_b_q};
				mac_op.flip = 1'b1;
				mac_op.acc  = acc2_q;
			end
			OP_COF: begin
				mac_op.v    = acc2_q;
				mac_op.flip = j_q[0];
				mac_op.acc  = (j_q == IDX_W'(0)) ? '0 : acc3_q;
			end
			OP_DET: begin
				mac_op.v    = acc3_q;
				mac_op.flip = i_q[0];
				mac_op.acc  = (i_q == IDX_W'(0)) ? '0 : det_q;
			end
			default: begin
				mac_op.v    = '0;
				mac_op.flip = 1'b0;
				mac_op.acc  = '0;
			end
		endcase
	end

	assign mac_start = (state_q == S_MAC_GO);
	assign div_start = (state_q == S_DIV_GO);

	mid4_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.op     (mac_op),
		.done   (mac_done),
		.res    (mac_res)
	);

	mid4_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc3_q),
		.den    (det_q),
		.negate (r_q[0] ^ c_q[0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			op_q         <= OP_PA_QB;
			out_phase_q  <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			r_q          <= '0;
			c_q          <= '0;
			load_count_q <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						load_count_q <= load_count_q + ADDR_W'(1);
						if (load_count_q == ADDR_W'(DIM*DIM-1)) begin
							state_q     <= S_FETCH;
							out_phase_q <= 1'b0;
							op_q        <= OP_PA_QB;
							i_q         <= '0;
							j_q         <= '0;
						end
					end
				end
				S_FETCH:  state_q <= S_MAC_GO;
				S_MAC_GO: state_q <= S_MAC_WAIT;
				S_MAC_WAIT: begin
					if (mac_done) begin
						unique case (op_q)
							OP_PA_QB: begin
								op_q    <= OP_PB_QA;
								state_q <= S_FETCH;
							end
							OP_PB_QA: begin
								op_q    <= OP_COF;
								state_q <= S_FETCH;
							end
							OP_COF: begin
								if (j_q != IDX_W'(2)) begin
									j_q     <= j_q + IDX_W'(1);
									op_q    <= OP_PA_QB;
									state_q <= S_FETCH;
								end else if (out_phase_q) begin
									state_q <= S_DIV_GO;
								end else begin
									op_q    <= OP_DET;
									state_q <= S_FETCH;
								end
							end
							OP_DET: begin
								j_q  <= '0;
								op_q <= OP_PA_QB;
								if (i_q != IDX_W'(DIM-1)) begin
									i_q     <= i_q + IDX_W'(1);
									state_q <= S_FETCH;
								end else begin
									out_phase_q <= 1'b1;
									r_q         <= '0;
									c_q         <= '0;
									state_q     <= (mac_res == '0) ? S_EMIT : S_FETCH;
								end
							end
							default: state_q <= S_LOAD;
						endcase
					end
				end
				S_DIV_GO: state_q <= S_DIV_WAIT;
				S_DIV_WAIT: if (div_done) state_q <= S_EMIT;
				S_EMIT: begin
					j_q  <= '0;
					op_q <= OP_PA_QB;
					if (last_rc) begin
						out_phase_q <= 1'b0;
						state_q     <= S_LOAD;
					end else begin
						c_q <= c_q + IDX_W'(1);
						if (c_q == IDX_W'(DIM-1))
							r_q <= r_q + IDX_W'(1);
						state_q <= (det_q == '0) ? S_EMIT : S_FETCH;
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Accumulators and the quotient hold payload only.
	always_ff @(posedge clk) begin
		if (state_q == S_MAC_WAIT && mac_done) begin
			unique case (op_q)
				OP_PA_QB, OP_PB_QA: acc2_q <= mac_res;
				OP_COF:             acc3_q <= mac_res;
				OP_DET:             det_q  <= mac_res;
				default:            acc2_q <= mac_res;
			endcase
		end
		if (state_q == S_DIV_WAIT && div_done)
			ie_q <= div_quo;
	end

	assign busy            = (state_q != S_LOAD);
	assign result_valid    = (state_q == S_EMIT);
	assign singular        = (det_q == '0);
	assign inverse_element = singular ? '0 : ie_q;
	assign row             = r_q;
	assign column          = c_q;
	assign determinant     = det_q;
	assign last_of_run     = last_rc;

	// A result only appears while the block is busy with a run.
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown outside a run");

	// The block is free again right after the final result.
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_of_run |=> !busy)
		else $error("block still busy after final result");

	// Results of a singular matrix walk row-major: a non-final one is followed by the next column.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_of_run && singular |=>
			result_valid && (column == $past(column) + IDX_W'(1)))
		else $error("singular results out of order");

	// No item is taken while a run is in progress.
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(load_count_q) || !$past(busy) || $past(state_q) == S_EMIT)
		else $error("load count moved during a run");
endmodule
`default_nettype wire
